>>> design/ptpe_pkg.sv
// Shared types, table constants and register codes for the pedal torque power estimator.
package ptpe_pkg;

    // Piecewise-linear sensor table
    localparam int TABLE_POINTS = 8;
    localparam int TABLE_MAX    = 16;
    localparam int SEG_W        = 4;
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'((TABLE_POINTS - 1) & (TABLE_MAX - 1));

    localparam logic [15:0] BP_ADC [TABLE_MAX] = '{
        16'd192, 16'd252, 16'd280, 16'd310, 16'd344, 16'd352, 16'd357, 16'd360,
        16'd360, 16'd360, 16'd360, 16'd360, 16'd360, 16'd360, 16'd360, 16'd360
    };
    localparam logic [15:0] BP_SLOPE [TABLE_MAX] = '{
        16'd17,  16'd17,  16'd18,  16'd33,  16'd88,  16'd313, 16'd480, 16'd500,
        16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500
    };

    // Reciprocal constants: x / 10 = (x * RECIP10) >> 35, exact for 32-bit x;
    // x / 3 = (x * RECIP3) >> 21, exact for x below 2^21.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam logic [20:0] RECIP3      = 21'd699051;
    localparam int          DIV3_SHIFT  = 21;
    localparam int          DIV32_SHIFT = 5;

    // Cadence limits
    localparam logic [7:0] CAD_STARTUP = 8'd30;
    localparam logic [7:0] CAD_PEDAL   = 8'd10;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration port
    localparam int         APB_ADDR_W      = 4;
    localparam logic [1:0] REG_ADC_OFFSET  = 2'd0;
    localparam logic [1:0] REG_STARTUP_THR = 2'd1;
    localparam logic [1:0] REG_FORCE_GAIN  = 2'd2;
    localparam logic [7:0] GAIN_RESET      = 8'd98;

    typedef struct packed {
        logic [9:0] adc_sample;
        logic [7:0] cadence_rpm;
    } in_item_t;

    typedef struct packed {
        logic [15:0] weight_x10;
        logic [15:0] torque_x100;
        logic [15:0] power_x10;
        logic        pedalling;
        logic        startup_ok;
    } out_item_t;

    typedef struct packed {
        logic [9:0] adc_offset;
        logic [9:0] startup_thr;
        logic [7:0] force_gain;
    } cfg_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [9:0] corr;
        logic [7:0] cadence;
        logic       startup;
        logic       pedalling;
        logic       blank;
    } q_entry_t;

    // Queue handshake toward either side
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> design/ptpe_front.sv
// Front end: accepts samples, removes ADC offset, runs the pedalling state machine.
module ptpe_front import ptpe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output q_entry_t q_entry
);

    logic       pedal_reg;
    logic       pedal_next;
    logic       startup;
    logic [9:0] corr;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign startup = (s_data.adc_sample >= cfg.startup_thr) ||
                     (s_data.cadence_rpm > CAD_STARTUP);
    assign corr    = (s_data.adc_sample >= cfg.adc_offset) ?
                     (s_data.adc_sample - cfg.adc_offset) : 10'd0;

    always_comb begin
        if (!pedal_reg) begin
            pedal_next = startup && (s_data.cadence_rpm > CAD_PEDAL);
        end else begin
            pedal_next = !((s_data.cadence_rpm == 8'd0) && (corr == 10'd0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pedal_reg <= 1'b0;
        end else if (q_push) begin
            pedal_reg <= pedal_next;
        end
    end

    always_comb begin
        q_entry.corr      = corr;
        q_entry.cadence   = s_data.cadence_rpm;
        q_entry.startup   = startup;
        q_entry.pedalling = pedal_next;
        // blank the signal while pedalling at standstill
        q_entry.blank     = pedal_next && (s_data.cadence_rpm == 8'd0);
    end

endmodule

>>> design/ptpe_queue.sv
// Short register queue of classified samples between front and back.
module ptpe_queue import ptpe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  q_ctrl_t  ctrl,
    input  q_entry_t wr_entry,
    output q_entry_t rd_entry,
    output q_stat_t  stat
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_entry   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (ctrl.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctrl.pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (ctrl.push && !ctrl.pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (ctrl.pop && !ctrl.push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/ptpe_back.sv
// Back end: table weight by segment MAC, weight offset, torque and power, output register.
module ptpe_back import ptpe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  q_entry_t  q_entry,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OFS  = 3'd3;
    localparam logic [2:0] S_TRQ  = 3'd4;
    localparam logic [2:0] S_PW1  = 3'd5;
    localparam logic [2:0] S_PW2  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    q_entry_t         ent_reg;
    logic [15:0]      abs_reg;
    logic [SEG_W-1:0] seg_reg;
    logic             done_reg;
    logic [31:0]      acc_reg;
    logic [63:0]      prod10_reg;
    logic             pend_reg;
    logic             pend_next;
    logic [15:0]      woff_reg;
    logic [15:0]      woff_next;
    logic [15:0]      w_reg;
    logic [15:0]      w_next;
    logic [15:0]      torque_reg;
    logic [23:0]      pprod_reg;
    logic [39:0]      p3_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic [SEG_W-1:0] seg_inc;
    logic [15:0]      part;
    logic [15:0]      slope;
    logic             hit;
    logic [31:0]      mac_prod;
    logic [15:0]      wraw;
    logic [15:0]      wblank;
    logic             capture;
    logic             out_free;
    logic [23:0]      trq_prod;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // One table segment per cycle
    always_comb begin
        seg_inc = seg_reg + 1'b1;
        hit     = 1'b0;
        if (seg_reg == SEG_LAST) begin
            slope = BP_SLOPE[SEG_LAST];
            part  = (abs_reg > BP_ADC[SEG_LAST]) ? (abs_reg - BP_ADC[SEG_LAST]) : 16'd0;
        end else begin
            slope = BP_SLOPE[seg_inc];
            if (done_reg) begin
                part = 16'd0;
            end else if (abs_reg < BP_ADC[seg_inc]) begin
                part = (seg_reg == '0) ? {6'd0, ent_reg.corr} : (abs_reg - BP_ADC[seg_reg]);
                hit  = 1'b1;
            end else begin
                part = BP_ADC[seg_inc] - BP_ADC[seg_reg];
            end
            // offset below the first breakpoint widens the first interval
            if ((seg_reg == '0) && ({6'd0, cfg.adc_offset} < BP_ADC[0])) begin
                part = part + (BP_ADC[0] - {6'd0, cfg.adc_offset});
            end
        end
        mac_prod = 32'(part) * 32'(slope);
    end

    // Weight offset capture and subtraction
    always_comb begin
        wraw      = (ent_reg.corr == 10'd0) ? 16'd0 : prod10_reg[DIV10_SHIFT +: 16];
        capture   = pend_reg && (ent_reg.corr != 10'd0);
        pend_next = pend_reg && !capture;
        woff_next = capture ? wraw : woff_reg;
        wblank    = ent_reg.blank ? 16'd0 : wraw;
        if (pend_next) begin
            w_next = wblank;
        end else begin
            w_next = (wblank > woff_next) ? (wblank - woff_next) : 16'd0;
        end
    end

    assign trq_prod = 24'(w_reg) * 24'(cfg.force_gain);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!q_empty) state_next = S_MAC;
            S_MAC:  if (seg_reg == SEG_LAST) state_next = S_DIV;
            S_DIV:  state_next = S_OFS;
            S_OFS:  state_next = S_TRQ;
            S_TRQ:  state_next = S_PW1;
            S_PW1:  state_next = S_PW2;
            S_PW2:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b1;
            woff_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OFS) begin
                pend_reg <= pend_next;
                woff_reg <= woff_next;
            end
            if ((state_reg == S_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                ent_reg  <= q_entry;
                abs_reg  <= 16'(q_entry.corr) + 16'(cfg.adc_offset);
                seg_reg  <= '0;
                done_reg <= 1'b0;
                acc_reg  <= 32'd0;
            end
            S_MAC: begin
                acc_reg  <= acc_reg + mac_prod;
                done_reg <= done_reg || hit;
                seg_reg  <= seg_inc;
            end
            S_DIV: prod10_reg <= 64'(acc_reg) * 64'(RECIP10);
            S_OFS: w_reg <= w_next;
            S_TRQ: torque_reg <= trq_prod[15:0];
            S_PW1: pprod_reg <= 24'(torque_reg) * 24'(ent_reg.cadence);
            S_PW2: p3_reg <= 40'(pprod_reg[23:DIV32_SHIFT]) * 40'(RECIP3);
            S_FIN: begin
                if (out_free) begin
                    m_data_reg.weight_x10  <= w_reg;
                    m_data_reg.torque_x100 <= torque_reg;
                    m_data_reg.power_x10   <= p3_reg[DIV3_SHIFT +: 16];
                    m_data_reg.pedalling   <= ent_reg.pedalling;
                    m_data_reg.startup_ok  <= ent_reg.startup;
                end
            end
        endcase
    end

endmodule

>>> design/pedal_torque_power_estimator.sv
// Top level of the pedal torque power estimator: APB registers, front, queue and back.
//
// Input channel s_*: one beat carries a raw 10-bit torque ADC sample and the
// pedal cadence in rpm. Result channel m_*: one beat per input beat, with the
// offset-corrected weight, torque, power and the pedalling / start-up flags.
// The front classifies a sample in the cycle it is accepted and parks it in a
// four-deep queue, so s_ready stays high until that queue fills.
// The back walks the sensor table one segment per clock on a shared
// multiply-accumulate, then works through the divide by ten, offset, torque
// and power steps and loads the output register; it takes the next beat from
// the queue only after that result has gone into the output register.
// While the receiver stalls, the result holds in the output register, the back
// finishes the next beat and waits, and the front keeps filling the queue.
// Synchronous reset (aresetn low) drops the queue and any result, returns the
// machine to idle, arms weight offset capture and loads register defaults
// (gain 98, offset and threshold zero). No clearing pass is needed.
// APB registers at byte offsets 0x0 adc_offset, 0x4 startup_threshold,
// 0x8 force_gain_x10; write them only while no beat is in flight.
module pedal_torque_power_estimator import ptpe_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [9:0] adc_offset_reg;
    logic [9:0] startup_thr_reg;
    logic [7:0] force_gain_reg;
    logic [1:0] reg_idx;
    logic       wr_en;
    cfg_t       cfg;

    q_ctrl_t    q_ctrl;
    q_stat_t    q_stat;
    q_entry_t   q_wr_entry;
    q_entry_t   q_rd_entry;

    // APB access: zero wait states, write on the access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_offset_reg  <= 10'd0;
            startup_thr_reg <= 10'd0;
            force_gain_reg  <= GAIN_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ADC_OFFSET:  adc_offset_reg  <= pwdata[9:0];
                REG_STARTUP_THR: startup_thr_reg <= pwdata[9:0];
                REG_FORCE_GAIN:  force_gain_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ADC_OFFSET:  prdata = {22'd0, adc_offset_reg};
            REG_STARTUP_THR: prdata = {22'd0, startup_thr_reg};
            REG_FORCE_GAIN:  prdata = {24'd0, force_gain_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.adc_offset  = adc_offset_reg;
    assign cfg.startup_thr = startup_thr_reg;
    assign cfg.force_gain  = force_gain_reg;

    // Classify and enqueue
    ptpe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_stat.full),
        .q_push  (q_ctrl.push),
        .q_entry (q_wr_entry)
    );

    // Decouple the two sides
    ptpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (q_ctrl),
        .wr_entry (q_wr_entry),
        .rd_entry (q_rd_entry),
        .stat     (q_stat)
    );

    // Compute and present the result
    ptpe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_stat.empty),
        .q_entry (q_rd_entry),
        .q_pop   (q_ctrl.pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> design/ptpe_checker.sv
// Port-level assertions for the pedal torque power estimator, bound to the top level.
module ptpe_port_props import ptpe_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Reset drops any pending result beat
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // Zero weight must give zero torque and zero power
    a_zero_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.weight_x10 == 16'd0)) |->
        ((m_data.torque_x100 == 16'd0) && (m_data.power_x10 == 16'd0)))
        else $error("nonzero torque or power with zero weight");

    // Stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

endmodule

bind pedal_torque_power_estimator ptpe_port_props u_ptpe_port_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/ptpe_checker.sv
// Checker for the pedal torque power estimator: tracks the registers, predicts each beat, compares.
module ptpe_checker import ptpe_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int                    bad_fields,
    output int                    readings_due
);

    logic [9:0]  zero_level;
    logic [9:0]  wake_level;
    logic [7:0]  gain;
    logic        pedal_on;
    logic        tare_armed;
    logic [15:0] tare_weight;
    int          errs;

    out_item_t   predicted_readings[$];

    function automatic logic [31:0] knee_adc(input int i);
        case (i)
            0:       return 32'd192;
            1:       return 32'd252;
            2:       return 32'd280;
            3:       return 32'd310;
            4:       return 32'd344;
            5:       return 32'd352;
            6:       return 32'd357;
            default: return 32'd360;
        endcase
    endfunction

    function automatic logic [31:0] knee_slope(input int i);
        case (i)
            0, 1:    return 32'd17;
            2:       return 32'd18;
            3:       return 32'd33;
            4:       return 32'd88;
            5:       return 32'd313;
            6:       return 32'd480;
            default: return 32'd500;
        endcase
    endfunction

    // Piecewise-linear conversion of a corrected sample to weight x10
    function automatic logic [15:0] sensor_weight(input logic [31:0] steps,
                                                  input logic [9:0] zero);
        logic [31:0] part [16];
        logic [31:0] level;
        logic [31:0] acc;
        int          last;
        bit          done;
        if (steps == 0)
            return 16'd0;
        last  = (TABLE_POINTS - 1) & (TABLE_MAX - 1);
        acc   = 0;
        done  = 0;
        for (int i = 0; i < 16; i++)
            part[i] = 0;
        level = (steps + 32'(zero)) & 32'hFFFF;
        for (int i = 0; i < last; i++) begin
            if (!done) begin
                if (level < knee_adc(i + 1)) begin
                    part[i] = (i == 0) ? steps : level - knee_adc(i);
                    done    = 1;
                end else begin
                    part[i] = knee_adc(i + 1) - knee_adc(i);
                end
            end
        end
        if (32'(zero) < knee_adc(0))
            part[0] = (part[0] + (knee_adc(0) - 32'(zero))) & 32'hFFFF;
        if (level > knee_adc(last))
            part[last] = level - knee_adc(last);
        for (int i = 0; i < last; i++)
            acc += part[i] * knee_slope(i + 1);
        acc += part[last] * knee_slope(last);
        return 16'((acc / 32'd10) & 32'hFFFF);
    endfunction

    // Advance the pedalling machine and tare state by one beat
    function automatic out_item_t estimate_outputs(input in_item_t beat);
        out_item_t   r;
        logic [31:0] smp;
        logic [31:0] cad;
        logic [31:0] corr;
        logic [31:0] steps;
        logic [31:0] w;
        logic [31:0] torque;
        logic        wake;
        logic [15:0] raw_w;
        smp  = 32'(beat.adc_sample);
        cad  = 32'(beat.cadence_rpm);
        wake = (smp >= 32'(wake_level)) || (cad > 32'd30);
        corr = (smp >= 32'(zero_level)) ? smp - 32'(zero_level) : 32'd0;
        if (!pedal_on) begin
            if (wake && cad > 32'd10)
                pedal_on = 1'b1;
        end else if (cad == 0 && corr == 0) begin
            pedal_on = 1'b0;
        end
        steps = (pedal_on && cad == 0) ? 32'd0 : corr;
        raw_w = sensor_weight(corr, zero_level);
        if (tare_armed && corr != 0) begin
            tare_armed  = 1'b0;
            tare_weight = raw_w;
        end
        w = 32'(sensor_weight(steps, zero_level));
        if (!tare_armed)
            w = (w > 32'(tare_weight)) ? w - 32'(tare_weight) : 32'd0;
        torque        = (w * 32'(gain)) & 32'hFFFF;
        r.weight_x10  = w[15:0];
        r.torque_x100 = torque[15:0];
        r.power_x10   = 16'(((torque * cad) / 32'd96) & 32'hFFFF);
        r.pedalling   = pedal_on;
        r.startup_ok  = wake;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            if (errs < 10)
                $display("mismatch %s: want %0d got %0d", what, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            zero_level  = '0;
            wake_level  = '0;
            gain        = 8'd98;
            pedal_on    = 1'b0;
            tare_armed  = 1'b1;
            tare_weight = '0;
            predicted_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ADC_OFFSET:  zero_level = pwdata[9:0];
                    REG_STARTUP_THR: wake_level = pwdata[9:0];
                    REG_FORCE_GAIN:  gain       = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predicted_readings.push_back(estimate_outputs(s_data));
            if (m_valid && m_ready) begin
                if (predicted_readings.size() == 0) begin
                    if (errs < 10)
                        $display("unexpected result beat: %h", m_data);
                    errs++;
                end else begin
                    want = predicted_readings.pop_front();
                    check_field("weight_x10", want.weight_x10, m_data.weight_x10);
                    check_field("torque_x100", want.torque_x100, m_data.torque_x100);
                    check_field("power_x10", want.power_x10, m_data.power_x10);
                    check_field("pedalling", 16'(want.pedalling), 16'(m_data.pedalling));
                    check_field("startup_ok", 16'(want.startup_ok), 16'(m_data.startup_ok));
                end
            end
        end
        bad_fields   <= errs;
        readings_due <= predicted_readings.size();
    end

    initial errs = 0;

endmodule

>>> verif/tb_pedal_torque_power_estimator.sv
// Testbench top for the pedal torque power estimator: clock, reset, stimulus and verdict.
module tb_pedal_torque_power_estimator import ptpe_pkg::*;;

    // Index past the last register; the block must ignore writes to it
    localparam logic [1:0] REG_NONE = 2'd3;

    // Cycles to let the back finish after the last result beat
    localparam int SETTLE = 40;
    // Watchdog limit on the length of the run
    localparam int CYCLE_LIMIT = 400000;
    localparam int BEATS_PER_SEG = 144;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    int bad_fields;
    int readings_due;
    int cycle_count;
    int snd_idle;
    int rcv_stall;
    int cur_zero;

    pedal_torque_power_estimator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ptpe_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .bad_fields   (bad_fields),
        .readings_due (readings_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run if the block hangs
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stall each cycle with the current probability
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    // Write one register: setup phase, access phase, then an idle phase so that
    // back-to-back writes never lower and raise psel in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ADC_OFFSET)
            cur_zero = int'(val[9:0]);
        @(negedge aclk);
    endtask

    // Send one beat; called just after a falling edge, returns just after one.
    // Hold valid and payload until the beat is taken.
    task automatic send_beat(input in_item_t beat);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_reading(input int sample, input int cad);
        in_item_t beat;
        beat.adc_sample  = 10'(sample);
        beat.cadence_rpm = 8'(cad);
        send_beat(beat);
    endtask

    // Drop valid, wait until every predicted beat has come back, then let the
    // back go quiet before touching the registers.
    task automatic drain();
        s_valid <= 1'b0;
        while (readings_due != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Random beat: samples cluster around the current zero level so the table
    // and the pedalling machine get exercised; cadence hugs its thresholds.
    function automatic in_item_t random_reading();
        in_item_t beat;
        int       pick;
        int       sample;
        int       cad;
        pick = $urandom_range(99);
        if (pick < 40)
            sample = $urandom_range(1023);
        else if (pick < 80)
            sample = cur_zero + $urandom_range(260);
        else if (cur_zero > 0)
            sample = $urandom_range(cur_zero - 1);
        else
            sample = $urandom_range(1023);
        if (sample > 1023)
            sample = 1023;
        pick = $urandom_range(99);
        if (pick < 25)
            cad = 0;
        else if (pick < 50)
            cad = $urandom_range(40);
        else
            cad = $urandom_range(255);
        beat.adc_sample  = 10'(sample);
        beat.cadence_rpm = 8'(cad);
        return beat;
    endfunction

    initial begin
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        snd_idle  = 0;
        rcv_stall = 0;
        cur_zero  = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: zero level below the first breakpoint, junk in the
        // upper data bits of the gain write, and a write past the last register.
        write_reg(REG_ADC_OFFSET, 32'd150);
        write_reg(REG_STARTUP_THR, 32'd300);
        write_reg(REG_FORCE_GAIN, 32'hABCD_EF62);
        write_reg(REG_NONE, 32'hFFFF_FFFF);

        send_reading(0, 0);         // zero corrected sample, no tare yet
        send_reading(100, 40);      // below zero level, start pedalling on cadence
        send_reading(200, 0);       // first nonzero sample while blanked: tare latches
        send_reading(1023, 255);    // both fields at their top
        send_reading(1023, 0);      // pedalling at zero cadence: blank
        send_reading(150, 0);       // zero cadence and zero signal: back to idle
        send_reading(299, 30);      // no start-up: below threshold, cadence at 30
        send_reading(299, 31);      // start-up on cadence
        send_reading(300, 11);      // start-up on threshold, still pedalling
        send_reading(191, 12);
        send_reading(192, 50);      // walk the breakpoints
        send_reading(251, 60);
        send_reading(252, 70);
        send_reading(280, 80);
        send_reading(310, 90);
        send_reading(344, 100);
        send_reading(352, 110);
        send_reading(357, 120);
        send_reading(360, 130);
        send_reading(361, 140);     // past the last breakpoint
        send_reading(512, 0);
        send_reading(149, 0);
        send_reading(0, 255);
        send_reading(1023, 1);
        drain();

        // Random part: four idling modes, two register settings each
        for (int seg = 0; seg < 8; seg++) begin
            case (seg / 2)
                0:       begin snd_idle = 0;  rcv_stall = 0;  end
                1:       begin snd_idle = 61; rcv_stall = 0;  end
                2:       begin snd_idle = 0;  rcv_stall = 61; end
                default: begin snd_idle = 37; rcv_stall = 37; end
            endcase
            case (seg)
                0: begin
                    write_reg(REG_ADC_OFFSET, 32'd0);
                    write_reg(REG_STARTUP_THR, 32'd0);
                    write_reg(REG_FORCE_GAIN, 32'd0);
                end
                1: begin
                    write_reg(REG_ADC_OFFSET, 32'd1023);
                    write_reg(REG_STARTUP_THR, 32'd1023);
                    write_reg(REG_FORCE_GAIN, 32'd255);
                end
                2: begin
                    write_reg(REG_ADC_OFFSET, 32'd192);
                    write_reg(REG_STARTUP_THR, 32'd1023);
                    write_reg(REG_FORCE_GAIN, 32'd255);
                end
                3: begin
                    write_reg(REG_ADC_OFFSET, 32'd191);
                    write_reg(REG_STARTUP_THR, 32'd0);
                    write_reg(REG_FORCE_GAIN, 32'd1);
                end
                default: begin
                    write_reg(REG_ADC_OFFSET, $urandom_range(360));
                    write_reg(REG_STARTUP_THR, $urandom_range(1023));
                    write_reg(REG_FORCE_GAIN, $urandom_range(255));
                end
            endcase
            for (int n = 0; n < BEATS_PER_SEG; n++)
                send_beat(random_reading());
            drain();
        end

        if (bad_fields == 0 && readings_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
